/* design/hall_key_note_event_engine_unit_defines.svh */
// Assertion macros used by the checker file.
`ifndef HALL_KEY_NOTE_EVENT_ENGINE_UNIT_DEFINES_SVH
`define HALL_KEY_NOTE_EVENT_ENGINE_UNIT_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define HKNE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define HKNE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/hkne_pkg.sv */
// ----------------------------------------------------------------------------
// hkne_pkg
// Types, widths and constants of the hall key note event engine.
// ----------------------------------------------------------------------------
package hkne_pkg;

    localparam int READING_W  = 10;
    localparam int IDX_W      = 5;
    localparam int NOTE_W     = 7;
    localparam int KIND_W     = 2;
    localparam int GAIN_W     = 4;
    localparam int KEYS_W     = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;
    localparam int PROD_W     = READING_W + GAIN_W;
    // holds 254*1023 + 1023 and the divisor shifted up by NOTE_W
    localparam int DIV_W      = 18;

    localparam logic [NOTE_W-1:0] MIDI_MAX = 7'd127;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MODE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FLOOR     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CEILING   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_NOTE      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_KEYS      = 3'd6;

    // register reset values
    localparam logic                  RST_MODE      = 1'b0;
    localparam logic [READING_W-1:0]  RST_THRESHOLD = 10'd350;
    localparam logic [GAIN_W-1:0]     RST_GAIN      = 4'd2;
    localparam logic [READING_W-1:0]  RST_FLOOR     = 10'd300;
    localparam logic [READING_W-1:0]  RST_CEILING   = 10'd480;
    localparam logic [NOTE_W-1:0]     RST_NOTE      = 7'd60;
    localparam logic [KEYS_W-1:0]     RST_KEYS      = 6'd3;

    localparam logic MODE_PRESSURE = 1'b0;
    localparam logic MODE_VELOCITY = 1'b1;

    typedef enum logic [KIND_W-1:0] {
        KIND_NOTE_ON  = 2'd0,
        KIND_NOTE_OFF = 2'd1,
        KIND_POLY     = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_EVAL,
        S_WAIT,
        S_OUT
    } t_state;

    typedef enum logic [1:0] {
        SRC_ZERO,
        SRC_VEL,
        SRC_PRESS
    } t_src;

    typedef struct packed {
        logic                 start;
        logic [READING_W-1:0] ceiling;
        logic [READING_W-1:0] floor_val;
        logic [READING_W-1:0] reading;
    } t_div_req;

    // pressure is nonzero iff span > 0, ceiling > reading and 254*(ceiling-reading) >= span
    function automatic logic press_nz(input logic [READING_W-1:0] ceiling,
                                      input logic [READING_W-1:0] floor_val,
                                      input logic [READING_W-1:0] reading);
        logic [DIV_W-1:0] diff;
        logic [DIV_W-1:0] span;
        logic [DIV_W-1:0] prod;
        diff = DIV_W'(ceiling - reading);
        span = DIV_W'(ceiling - floor_val);
        prod = (diff << 8) - (diff << 1);
        if (ceiling <= floor_val || ceiling <= reading) begin
            return 1'b0;
        end
        return prod >= span;
    endfunction

endpackage

/* design/hkne_ram.sv */
// ----------------------------------------------------------------------------
// hkne_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module hkne_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* design/hkne_div.sv */
// ----------------------------------------------------------------------------
// hkne_div
// Pressure divider: round(127*(ceiling-reading)/span), clamped to 127.
// Restoring division, one quotient bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module hkne_div (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  hkne_pkg::t_div_req      i_req,
    output logic                    o_done,
    output logic [hkne_pkg::NOTE_W-1:0] o_quot
);
    import hkne_pkg::*;

    localparam int CNT_W = $clog2(NOTE_W + 1);

    logic [DIV_W-1:0]  r_rem;
    logic [DIV_W-1:0]  r_dsh;
    logic [NOTE_W-1:0] r_quot;
    logic              r_sat;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [DIV_W-1:0] st_diff;
    logic [DIV_W-1:0] st_span;
    logic [DIV_W-1:0] st_dividend;
    logic [DIV_W-1:0] st_divisor;

    // dividend 2*127*(c-r) + span, divisor 2*span
    always_comb begin
        st_diff     = DIV_W'(i_req.ceiling - i_req.reading);
        st_span     = DIV_W'(i_req.ceiling - i_req.floor_val);
        st_dividend = (st_diff << 8) - (st_diff << 1) + st_span;
        st_divisor  = st_span << 1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NOTE_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem  <= st_dividend;
            r_dsh  <= st_divisor << (NOTE_W - 1);
            r_sat  <= st_dividend >= (st_divisor << NOTE_W);
            r_quot <= '0;
        end else if (r_busy) begin
            if (r_rem >= r_dsh) begin
                r_rem  <= r_rem - r_dsh;
                r_quot <= {r_quot[NOTE_W-2:0], 1'b1};
            end else begin
                r_quot <= {r_quot[NOTE_W-2:0], 1'b0};
            end
            r_dsh <= r_dsh >> 1;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_sat ? MIDI_MAX : r_quot;

endmodule

/* design/hall_key_note_event_engine_unit.sv */
// ----------------------------------------------------------------------------
// hall_key_note_event_engine_unit
// Per-sensor last-reading store and note event generator.
//
//   channel  direction  handshake                   words
//   input    in         i_in_valid / o_in_ready     sensor_index, reading
//   output   out        o_out_valid / i_out_ready   event_kind, note, amount, key_index
//   config   in         i_cfg_we (no wait)          index, data
//
// One word at a time: read, write-back, evaluate, emit. A pressure value
// also goes through the 7-step divider. A word whose sensor is inactive gets
// only its store update; a word beyond the store is dropped unstored.
// Reset clears the per-entry valid bits; an unwritten entry reads as zero.
// A full output register holds the sequencer in its emit step until taken.
// ----------------------------------------------------------------------------
module hall_key_note_event_engine_unit #(
    parameter int SENSOR_COUNT = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [hkne_pkg::IDX_W-1:0]        i_sensor_index,
    input  logic [hkne_pkg::READING_W-1:0]    i_reading,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [hkne_pkg::KIND_W-1:0]       o_event_kind,
    output logic [hkne_pkg::NOTE_W-1:0]       o_note,
    output logic [hkne_pkg::NOTE_W-1:0]       o_amount,
    output logic [hkne_pkg::IDX_W-1:0]        o_key_index,
    input  logic                              i_cfg_we,
    input  logic [hkne_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [hkne_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import hkne_pkg::*;

    localparam int AW = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;

    // configuration
    logic                 r_mode;
    logic [READING_W-1:0] r_threshold;
    logic [GAIN_W-1:0]    r_gain;
    logic [READING_W-1:0] r_floor;
    logic [READING_W-1:0] r_ceiling;
    logic [NOTE_W-1:0]    r_note_cfg;
    logic [KEYS_W-1:0]    r_keys;

    // sequencer
    t_state               r_state, n_state;
    logic [AW-1:0]        r_addr;
    logic                 r_in_range;
    logic [IDX_W-1:0]     r_idx;
    logic [READING_W-1:0] r_now;
    logic [READING_W-1:0] r_last;
    logic [SENSOR_COUNT-1:0] r_valid;
    logic                 r_emit;
    t_kind                r_kind;
    t_src                 r_src;
    logic [PROD_W-1:0]    r_prod;

    // output register
    logic                 r_out_valid;
    t_kind                r_out_kind;
    logic [NOTE_W-1:0]    r_out_note;
    logic [NOTE_W-1:0]    r_out_amount;
    logic [IDX_W-1:0]     r_out_key;

    logic                 in_accept;
    logic [IDX_W+AW-1:0]  in_idx_ext;
    logic [AW-1:0]        in_addr;
    logic                 in_range;
    logic                 ram_we;
    logic [READING_W-1:0] ram_rdata;
    logic [READING_W-1:0] rd_last;
    logic                 idx_active;
    logic                 out_load;
    t_div_req             div_req;
    logic                 div_done;
    logic [NOTE_W-1:0]    div_quot;
    logic                 dec_emit;
    t_kind                dec_kind;
    t_src                 dec_src;
    logic                 now_nz;
    logic                 last_nz;
    logic [NOTE_W-1:0]    vel_amount;
    logic [NOTE_W-1:0]    out_amount;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_accept  = i_in_valid && o_in_ready;
    assign in_idx_ext = {{AW{1'b0}}, i_sensor_index};
    assign in_addr    = in_idx_ext[AW-1:0];
    assign in_range   = 32'(i_sensor_index) < SENSOR_COUNT;
    assign idx_active = {1'b0, r_idx} < r_keys;
    assign rd_last    = r_valid[r_addr] ? ram_rdata : '0;

    hkne_ram #(
        .WIDTH (READING_W),
        .DEPTH (SENSOR_COUNT)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_addr),
        .i_wdata (r_now),
        .i_raddr (in_addr),
        .o_rdata (ram_rdata)
    );

    hkne_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= RST_MODE;
            r_threshold <= RST_THRESHOLD;
            r_gain      <= RST_GAIN;
            r_floor     <= RST_FLOOR;
            r_ceiling   <= RST_CEILING;
            r_note_cfg  <= RST_NOTE;
            r_keys      <= RST_KEYS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MODE:      r_mode      <= i_cfg_data[0];
                CFG_THRESHOLD: r_threshold <= i_cfg_data[READING_W-1:0];
                CFG_GAIN:      r_gain      <= i_cfg_data[GAIN_W-1:0];
                CFG_FLOOR:     r_floor     <= i_cfg_data[READING_W-1:0];
                CFG_CEILING:   r_ceiling   <= i_cfg_data[READING_W-1:0];
                CFG_NOTE:      r_note_cfg  <= i_cfg_data[NOTE_W-1:0];
                CFG_KEYS:      r_keys      <= i_cfg_data[KEYS_W-1:0];
                default: ;
            endcase
        end
    end

    // event decision from last and new reading
    always_comb begin
        now_nz   = press_nz(r_ceiling, r_floor, r_now);
        last_nz  = press_nz(r_ceiling, r_floor, r_last);
        dec_emit = 1'b0;
        dec_kind = KIND_NOTE_ON;
        dec_src  = SRC_ZERO;
        if (r_mode == MODE_PRESSURE) begin
            if (now_nz) begin
                dec_emit = 1'b1;
                dec_kind = last_nz ? KIND_POLY : KIND_NOTE_ON;
                dec_src  = SRC_PRESS;
            end else if (last_nz) begin
                dec_emit = 1'b1;
                dec_kind = KIND_NOTE_OFF;
            end
        end else begin
            if (r_now <= r_threshold && r_threshold < r_last) begin
                dec_emit = 1'b1;
                dec_kind = KIND_NOTE_ON;
                dec_src  = SRC_VEL;
            end else if (r_last <= r_threshold && r_threshold < r_now) begin
                dec_emit = 1'b1;
                dec_kind = KIND_NOTE_OFF;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state           = r_state;
        ram_we            = 1'b0;
        out_load          = 1'b0;
        div_req.start     = 1'b0;
        div_req.ceiling   = r_ceiling;
        div_req.floor_val = r_floor;
        div_req.reading   = r_now;
        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                // store write-back; the next read is issued only after return to idle
                ram_we  = r_in_range;
                n_state = (r_in_range && idx_active) ? S_EVAL : S_IDLE;
            end
            S_EVAL: begin
                div_req.start = dec_emit && (dec_src == SRC_PRESS);
                n_state       = div_req.start ? S_WAIT : S_OUT;
            end
            S_WAIT: begin
                if (div_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_emit) begin
                    n_state = S_IDLE;
                end else if (!r_out_valid || i_out_ready) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (ram_we) begin
            r_valid[r_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_addr     <= in_addr;
            r_in_range <= in_range;
            r_idx      <= i_sensor_index;
            r_now      <= i_reading;
        end
        if (r_state == S_READ) begin
            r_last <= rd_last;
        end
        if (r_state == S_EVAL) begin
            r_emit <= dec_emit;
            r_kind <= dec_kind;
            r_src  <= dec_src;
            r_prod <= PROD_W'(r_gain) * PROD_W'(r_last - r_now);
        end
    end

    assign vel_amount = (|r_prod[PROD_W-1:NOTE_W]) ? MIDI_MAX : r_prod[NOTE_W-1:0];

    always_comb begin
        unique case (r_src)
            SRC_VEL:   out_amount = vel_amount;
            SRC_PRESS: out_amount = div_quot;
            default:   out_amount = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_kind   <= r_kind;
            r_out_note   <= r_note_cfg;
            r_out_amount <= out_amount;
            r_out_key    <= r_idx;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_event_kind = r_out_kind;
    assign o_note       = r_out_note;
    assign o_amount     = r_out_amount;
    assign o_key_index  = r_out_key;

endmodule

/* design/hkne_checker.sv */
// ----------------------------------------------------------------------------
// hkne_checker
// Port-level checks of the note event engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "hall_key_note_event_engine_unit_defines.svh"

module hkne_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           o_in_ready,
    input  logic                           o_out_valid,
    input  logic                           i_out_ready,
    input  logic [hkne_pkg::KIND_W-1:0]    o_event_kind,
    input  logic [hkne_pkg::NOTE_W-1:0]    o_amount,
    input  logic [hkne_pkg::IDX_W-1:0]     o_key_index
);
    import hkne_pkg::*;

    // one word in flight: no second accept right behind the first
    `HKNE_ASSERT_NEXT(a_one_in_flight, i_in_valid && o_in_ready, !o_in_ready, "accept right after accept")

    // a result needs at least read and evaluate steps after its word
    `HKNE_ASSERT_NOW(a_result_latency, $rose(o_out_valid), !$past(i_in_valid && o_in_ready), "result too early")

    // stalled result holds
    `HKNE_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_amount) && $stable(o_event_kind) && $stable(o_key_index), "stalled result changed")

endmodule

bind hall_key_note_event_engine_unit hkne_checker u_hkne_checker (.*);

/* dv/hall_key_note_event_engine_unit_tb.sv */
// ----------------------------------------------------------------------------
// hall_key_note_event_engine_unit_tb
// Self-checking bench for the hall key note event engine. A queue of sensor
// words is driven through the input handshake. Each accepted word updates a
// local copy of the per-sensor store, and the note event predicted from that
// and the register copy goes into a queue. Each event taken from the output is
// checked field by field against that queue. Directed words come first, then
// random phases with changing registers and idle patterns.
// ----------------------------------------------------------------------------
module hall_key_note_event_engine_unit_tb;
    import hkne_pkg::*;

    localparam int SENSOR_COUNT   = 32;
    localparam int SETTLE_CYCLES  = 32;
    localparam int HOLD_OFF_LEN   = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_PHASES  = 12;
    localparam int PHASE_WORDS    = 110;

    typedef struct packed {
        logic [IDX_W-1:0]     idx;
        logic [READING_W-1:0] value;
    } sensor_word_t;

    typedef struct {
        t_kind             kind;
        logic [NOTE_W-1:0] note;
        logic [NOTE_W-1:0] amount;
        logic [IDX_W-1:0]  key;
    } note_event_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic [IDX_W-1:0]      i_sensor_index = '0;
    logic [READING_W-1:0]  i_reading = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic [KIND_W-1:0]     o_event_kind;
    logic [NOTE_W-1:0]     o_note;
    logic [NOTE_W-1:0]     o_amount;
    logic [IDX_W-1:0]      o_key_index;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // register copy, reset values
    logic                  cfg_mode = RST_MODE;
    logic [READING_W-1:0]  cfg_thresh = RST_THRESHOLD;
    logic [GAIN_W-1:0]     cfg_gain = RST_GAIN;
    logic [READING_W-1:0]  cfg_floor = RST_FLOOR;
    logic [READING_W-1:0]  cfg_ceil = RST_CEILING;
    logic [NOTE_W-1:0]     cfg_note = RST_NOTE;
    logic [KEYS_W-1:0]     cfg_keys = RST_KEYS;

    logic [READING_W-1:0]  last_seen [SENSOR_COUNT] = '{default: '0};

    sensor_word_t pending_words[$];
    note_event_t  expected_events[$];

    int fail_count = 0;
    int sender_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_trigger = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int stall_cycles = 0;

    hall_key_note_event_engine_unit #(
        .SENSOR_COUNT(SENSOR_COUNT)
    ) u_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_sensor_index(i_sensor_index),
        .i_reading(i_reading),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_event_kind(o_event_kind),
        .o_note(o_note),
        .o_amount(o_amount),
        .o_key_index(o_key_index),
        .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic flag_error(input string msg);
        $display("ERROR: %s", msg);
        fail_count++;
    endtask

    // rounded, clamped map of a reading onto 0..127 pressure
    function automatic int pressure_of(input logic [READING_W-1:0] rd);
        int c;
        int f;
        int r;
        int span;
        int num;
        int q;
        c = cfg_ceil;
        f = cfg_floor;
        r = rd;
        span = c - f;
        if (span <= 0) return 0;
        num = 127 * (c - r);
        if (num <= 0) return 0;
        q = (2 * num + span) / (2 * span);
        if (q > 127) q = 127;
        return q;
    endfunction

    function automatic int velocity_of(input logic [READING_W-1:0] prev,
                                       input logic [READING_W-1:0] now);
        int p;
        int n;
        int g;
        int v;
        p = prev;
        n = now;
        g = cfg_gain;
        v = g * (p - n);
        if (v < 0) v = 0;
        if (v > 127) v = 127;
        return v;
    endfunction

    function automatic void predict_note_event(input logic [IDX_W-1:0] idx,
                                               input logic [READING_W-1:0] now);
        logic [READING_W-1:0] prev;
        int          p_now;
        int          p_prev;
        bit          emit;
        note_event_t ev;
        prev = last_seen[idx];
        last_seen[idx] = now;
        emit = 1'b0;
        ev.kind = KIND_NOTE_ON;
        ev.amount = '0;
        ev.note = cfg_note;
        ev.key = idx;
        if (idx >= cfg_keys) return;
        if (cfg_mode == MODE_PRESSURE) begin
            p_now = pressure_of(now);
            p_prev = pressure_of(prev);
            if (p_now > 0) begin
                emit = 1'b1;
                ev.kind = (p_prev == 0) ? KIND_NOTE_ON : KIND_POLY;
                ev.amount = p_now[NOTE_W-1:0];
            end else if (p_prev > 0) begin
                emit = 1'b1;
                ev.kind = KIND_NOTE_OFF;
            end
        end else begin
            if (now <= cfg_thresh && cfg_thresh < prev) begin
                emit = 1'b1;
                ev.kind = KIND_NOTE_ON;
                ev.amount = 7'(velocity_of(prev, now));
            end else if (prev <= cfg_thresh && cfg_thresh < now) begin
                emit = 1'b1;
                ev.kind = KIND_NOTE_OFF;
            end
        end
        if (emit) expected_events.push_back(ev);
    endfunction

    // input driver
    always @(posedge i_clk) begin
        sensor_word_t w;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                predict_note_event(i_sensor_index, i_reading);
            end
            if (!(i_in_valid && !o_in_ready)) begin
                if (pending_words.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                    w = pending_words.pop_front();
                    i_in_valid <= 1'b1;
                    i_sensor_index <= w.idx;
                    i_reading <= w.value;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // output monitor and ready generation
    always @(posedge i_clk) begin
        note_event_t ev;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_events.size() == 0) begin
                    flag_error($sformatf("event kind %0d key %0d with nothing expected",
                                         o_event_kind, o_key_index));
                end else begin
                    ev = expected_events.pop_front();
                    if (o_event_kind !== ev.kind)
                        flag_error($sformatf("event_kind got %0d expected %0d",
                                             o_event_kind, ev.kind));
                    if (o_note !== ev.note)
                        flag_error($sformatf("note got %0d expected %0d", o_note, ev.note));
                    if (o_amount !== ev.amount)
                        flag_error($sformatf("amount got %0d expected %0d",
                                             o_amount, ev.amount));
                    if (o_key_index !== ev.key)
                        flag_error($sformatf("key_index got %0d expected %0d",
                                             o_key_index, ev.key));
                end
            end
            if (hold_trigger != hold_seen) begin
                hold_seen <= hold_trigger;
                hold_left <= HOLD_OFF_LEN;
                i_out_ready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial begin
        wait (stall_cycles >= WATCHDOG_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val[CFG_DATA_W-1:0];
        case (idx)
            CFG_MODE:      cfg_mode = val[0];
            CFG_THRESHOLD: cfg_thresh = val[READING_W-1:0];
            CFG_GAIN:      cfg_gain = val[GAIN_W-1:0];
            CFG_FLOOR:     cfg_floor = val[READING_W-1:0];
            CFG_CEILING:   cfg_ceil = val[READING_W-1:0];
            CFG_NOTE:      cfg_note = val[NOTE_W-1:0];
            CFG_KEYS:      cfg_keys = val[KEYS_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic apply_config(input int unsigned mode, input int unsigned thr,
                                input int unsigned gain, input int unsigned flr,
                                input int unsigned ceil, input int unsigned note,
                                input int unsigned keys);
        write_reg(CFG_MODE, mode);
        write_reg(CFG_THRESHOLD, thr);
        write_reg(CFG_GAIN, gain);
        write_reg(CFG_FLOOR, flr);
        write_reg(CFG_CEILING, ceil);
        write_reg(CFG_NOTE, note);
        write_reg(CFG_KEYS, keys);
        @(negedge i_clk);
    endtask

    // block idle: all words taken, all events out, pipeline settled
    task automatic wait_idle();
        do @(negedge i_clk);
        while (pending_words.size() != 0 || i_in_valid || expected_events.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic add_word(input int unsigned idx, input int unsigned value);
        sensor_word_t w;
        w.idx = idx[IDX_W-1:0];
        w.value = value[READING_W-1:0];
        pending_words.push_back(w);
    endtask

    function automatic int unsigned pick_reading();
        int lo;
        int hi;
        int sel;
        int c;
        int f;
        int t;
        c = cfg_ceil;
        f = cfg_floor;
        t = cfg_thresh;
        sel = $urandom_range(9);
        if (cfg_mode == MODE_PRESSURE) begin
            lo = (f > c ? c : f) - 30;
            hi = (f > c ? f : c) + 30;
        end else begin
            lo = t - 150;
            hi = t + 150;
        end
        if (lo < 0) lo = 0;
        if (hi > 1023) hi = 1023;
        if (sel < 6) return $urandom_range(hi, lo);
        if (sel < 8) return $urandom_range(1023);
        case ($urandom_range(3))
            0: return 0;
            1: return 1023;
            2: return (cfg_mode == MODE_PRESSURE) ? f : t;
            default: return (cfg_mode == MODE_PRESSURE) ? c : ((t < 1023) ? t + 1 : t);
        endcase
    endfunction

    function automatic int unsigned pick_index();
        int eff;
        eff = (cfg_keys > 32) ? 32 : cfg_keys;
        if (eff == 0 || $urandom_range(4) == 0) return $urandom_range(31);
        return $urandom_range(eff - 1);
    endfunction

    task automatic random_config(input int p);
        int unsigned mode;
        int unsigned thr;
        int unsigned gain;
        int unsigned flr;
        int unsigned ceil;
        int unsigned note;
        int unsigned keys;
        mode = $urandom_range(1);
        thr = $urandom_range(900, 100);
        gain = $urandom_range(15);
        flr = $urandom_range(800);
        ceil = flr + $urandom_range(223, 1);
        if (ceil > 1023) ceil = 1023;
        if ($urandom_range(9) == 0) ceil = $urandom_range(flr);
        note = $urandom_range(127);
        keys = $urandom_range(32, 1);
        case (p)
            1: begin thr = 0; gain = 15; keys = 32; end
            2: begin mode = MODE_PRESSURE; flr = 0; ceil = 1023; end
            4: begin mode = MODE_PRESSURE; keys = 8; end
            6: begin keys = 63; note = 127; end
            7: begin note = 0; gain = 0; end
            9: begin mode = MODE_VELOCITY; thr = 1023; gain = 15; end
            default: ;
        endcase
        apply_config(mode, thr, gain, flr, ceil, note, keys);
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // pressure mode at reset values; stored zero maps to full pressure
        add_word(0, 1023);
        add_word(0, 400);
        add_word(0, 300);
        add_word(0, 0);
        add_word(0, 480);
        add_word(0, 479);
        add_word(1, 350);
        add_word(2, 700);
        add_word(31, 0);
        add_word(3, 200);
        wait_idle();

        // velocity: full-scale drop clamps, one-step drop, release
        apply_config(MODE_VELOCITY, 350, 15, 300, 480, 127, 3);
        add_word(0, 1023);
        add_word(0, 0);
        add_word(0, 351);
        add_word(0, 350);
        add_word(0, 350);
        add_word(0, 1023);
        wait_idle();

        // threshold at both ends, zero gain, top sensor
        apply_config(MODE_VELOCITY, 0, 0, 300, 480, 0, 32);
        add_word(31, 1023);
        add_word(31, 0);
        add_word(31, 1);
        wait_idle();
        apply_config(MODE_VELOCITY, 1023, 15, 300, 480, 0, 32);
        add_word(31, 0);
        add_word(31, 1023);
        wait_idle();

        // span of two: exact half rounds up
        apply_config(MODE_PRESSURE, 350, 2, 100, 102, 60, 63);
        add_word(5, 101);
        add_word(5, 102);
        add_word(5, 0);
        wait_idle();

        // degenerate span never emits
        apply_config(MODE_PRESSURE, 350, 2, 500, 500, 60, 63);
        add_word(6, 0);
        add_word(6, 1023);
        wait_idle();
        apply_config(MODE_PRESSURE, 350, 2, 1023, 0, 60, 0);
        add_word(0, 0);
        wait_idle();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            random_config(p);
            case (p % 4)
                0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin sender_idle_pct = 71; recv_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  recv_stall_pct = 71; end
                default: begin sender_idle_pct = 8; recv_stall_pct = 8; end
            endcase
            // long output hold-off so the block backs up into its input
            if (p == 4) hold_trigger++;
            for (int n = 0; n < PHASE_WORDS; n++) add_word(pick_index(), pick_reading());
            wait_idle();
        end

        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
